// ===== rtl/plx_pkg.sv =====
// Shared types, character codes, token kinds and keyword table for the lexer.
// Used by every module of the lexer; depends on nothing.
package plx_pkg;

   // Lexeme text buffer: at least 8 bytes so that "function" can match
   localparam int KEYWORD_MAX_LEN = 7;
   localparam int BUF_LEN         = (KEYWORD_MAX_LEN > 8) ? KEYWORD_MAX_LEN : 8;
   localparam int TEXT_W          = BUF_LEN * 8;
   localparam int KW_LEN_W        = $clog2(BUF_LEN + 1);
   localparam int KW_COUNT        = 28;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int CH_W   = 8;
   localparam int KIND_W = 6;
   localparam int LEN_W  = 8;

   // Character codes
   localparam logic [CH_W-1:0] CH_0       = 8'h30;
   localparam logic [CH_W-1:0] CH_9       = 8'h39;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CH_W-1:0] CH_EQ      = 8'h3D;
   localparam logic [CH_W-1:0] CH_LT      = 8'h3C;
   localparam logic [CH_W-1:0] CH_GT      = 8'h3E;
   localparam logic [CH_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [CH_W-1:0] CH_LPAREN  = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN  = 8'h29;
   localparam logic [CH_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [CH_W-1:0] CH_RBRACK  = 8'h5D;
   localparam logic [CH_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [CH_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CH_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_EOL     = 8'h0A;

   // Token kinds
   localparam logic [KIND_W-1:0] K_ID   = 6'd0;
   localparam logic [KIND_W-1:0] K_NUM  = 6'd1;
   localparam logic [KIND_W-1:0] K_EOF  = 6'd23;
   localparam logic [KIND_W-1:0] K_ERR  = 6'd24;
   // operator states are numbered kind + 3
   localparam logic [KIND_W-1:0] OP_KIND_OFFSET = 6'd3;

   // Automaton states
   typedef enum logic [4:0] {
      ST_START  = 5'd0,
      ST_ID     = 5'd1,
      ST_INT    = 5'd2,
      ST_POINT  = 5'd3,
      ST_REAL   = 5'd4,
      ST_PLUS   = 5'd5,
      ST_MINUS  = 5'd6,
      ST_STAR   = 5'd7,
      ST_SLASH  = 5'd8,
      ST_EQ     = 5'd9,
      ST_LT     = 5'd10,
      ST_NE     = 5'd11,
      ST_LE     = 5'd12,
      ST_GT     = 5'd13,
      ST_GE     = 5'd14,
      ST_COLON  = 5'd15,
      ST_ASSIGN = 5'd16,
      ST_LPAREN = 5'd17,
      ST_RPAREN = 5'd18,
      ST_LBRACK = 5'd19,
      ST_RBRACK = 5'd20,
      ST_SEMI   = 5'd21,
      ST_DOT    = 5'd22,
      ST_COMMA  = 5'd23,
      ST_SPACE  = 5'd24,
      ST_EOL    = 5'd25
   } lexer_state_type;

   // Keyword table: text right-justified, first character in the highest used byte
   localparam logic [TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
      TEXT_W'("program"), TEXT_W'("type"),    TEXT_W'("record"), TEXT_W'("var"),
      TEXT_W'("function"),TEXT_W'("begin"),   TEXT_W'("end"),    TEXT_W'("of"),
      TEXT_W'("if"),      TEXT_W'("else"),    TEXT_W'("for"),    TEXT_W'("do"),
      TEXT_W'("then"),    TEXT_W'("to"),      TEXT_W'("downto"), TEXT_W'("read"),
      TEXT_W'("readln"),  TEXT_W'("write"),   TEXT_W'("writeln"),TEXT_W'("and"),
      TEXT_W'("or"),      TEXT_W'("not"),     TEXT_W'("xor"),    TEXT_W'("div"),
      TEXT_W'("mod"),     TEXT_W'("integer"), TEXT_W'("real"),   TEXT_W'("boolean")
   };
   localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      KW_LEN_W'(7), KW_LEN_W'(4), KW_LEN_W'(6), KW_LEN_W'(3),
      KW_LEN_W'(8), KW_LEN_W'(5), KW_LEN_W'(3), KW_LEN_W'(2),
      KW_LEN_W'(2), KW_LEN_W'(4), KW_LEN_W'(3), KW_LEN_W'(2),
      KW_LEN_W'(4), KW_LEN_W'(2), KW_LEN_W'(6), KW_LEN_W'(4),
      KW_LEN_W'(6), KW_LEN_W'(5), KW_LEN_W'(7), KW_LEN_W'(3),
      KW_LEN_W'(2), KW_LEN_W'(3), KW_LEN_W'(3), KW_LEN_W'(3),
      KW_LEN_W'(3), KW_LEN_W'(7), KW_LEN_W'(4), KW_LEN_W'(7)
   };
   localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
      6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
      6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
      6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48,
      6'd49, 6'd50, 6'd50, 6'd50
   };

   // One result item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  lexeme_length;
      logic              last;
   } rsp_item_type;

   // Results of one accepted transaction, in order: the lexeme, then end of file
   typedef struct packed {
      logic         lex_vld;
      logic         eof_vld;
      rsp_item_type lex_item;
   } push_type;

endpackage

// ===== rtl/pascal_subset_lexer_core.sv =====
// Top level of the Pascal subset lexer: automaton plus result queue.
// Depends on plx_pkg, plx_step and plx_rsp_queue.
//
//   channel | direction | payload
//   req     | in        | tdata: ch[7:0]; tlast: is_end
//   rsp     | out       | tdata: kind[5:0], lexeme_length[13:6], zero[15:14]; tlast: last
//
// One character transaction is taken per cycle while req_tready is high; the
// automaton and keyword compare settle in the cycle of acceptance; results
// enter a 4-entry queue and are registered there before they appear on rsp.
// An end transaction causes up to two results; these leave one per cycle if rsp is ready.
// req_tready drops while fewer than two queue entries are free (rsp stalls).
// Reset is synchronous and returns the automaton to its start state.
module pascal_subset_lexer_core
   import plx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // is_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] kind, [13:6] lexeme_length, [15:14] zero
   output logic        rsp_tlast    // last
);

   logic         accept;
   push_type     push;
   rsp_item_type out_item;

   assign accept = req_tvalid && req_tready;

   plx_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_tdata),
      .is_end (req_tlast),
      .push   (push)
   );

   plx_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (req_tready),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .out_item (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.lexeme_length, out_item.kind};
   assign rsp_tlast = out_item.last;

`ifndef SYNTHESIS
   // an end transaction always yields a result in the next cycle
   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> rsp_tvalid)
      else $error("no result after end transaction");

   // two results at once only for an end transaction
   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      push.lex_vld && push.eof_vld |-> req_tlast)
      else $error("double push without end");

   // nothing is pushed without an accepted transaction
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (push.lex_vld || push.eof_vld) |-> accept)
      else $error("push without accepted transaction");

   // a lexeme result pushed by a character transaction is the last of it
   a_lex_last: assert property (@(posedge clock) disable iff (reset)
      push.lex_vld && !req_tlast |-> push.lex_item.last)
      else $error("lexeme result not marked last");
`endif

endmodule

// ===== rtl/plx_kw_match.sv =====
// Keyword compare: matches the buffered lexeme text against the keyword table.
// Depends on plx_pkg.
module plx_kw_match
   import plx_pkg::*;
(
   input  logic [TEXT_W-1:0] text,
   input  logic [LEN_W-1:0]  text_count,
   input  logic              no_keyword,
   output logic [KIND_W-1:0] id_kind
);

   // Every keyword is compared in parallel; keyword texts are distinct
   always_comb begin
      logic [TEXT_W-1:0] mask;
      id_kind = K_ID;
      for (int i = 0; i < KW_COUNT; i++) begin
         mask = '0;
         for (int j = 0; j < BUF_LEN; j++) begin
            if (j < int'(KW_LEN[i])) mask[j*8 +: 8] = 8'hFF;
         end
         if (text_count == LEN_W'(KW_LEN[i]) && (text & mask) == KW_TEXT[i]) begin
            id_kind = KW_KIND[i];
         end
      end
      if (no_keyword || text_count > LEN_W'(BUF_LEN)) id_kind = K_ID;
   end

endmodule

// ===== rtl/plx_step.sv =====
// Lexer automaton: state registers, next-state logic and the results of one
// accepted transaction. Depends on plx_pkg and plx_kw_match.
module plx_step
   import plx_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [CH_W-1:0] ch,
   input  logic            is_end,
   output push_type        push
);

   lexer_state_type   state_ff, state_in;
   logic [TEXT_W-1:0] text_ff, text_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              nokw_ff, nokw_in;

   logic [KIND_W-1:0] id_kind;
   logic [KIND_W-1:0] pend_kind;
   lexer_state_type   cont_nx, start_nx;
   logic              flush;
   logic [LEN_W-1:0]  base_count;
   logic              base_nokw;
   logic              is_digit, is_letter;

   plx_kw_match u_kw_match (
      .text       (text_ff),
      .text_count (count_ff),
      .no_keyword (nokw_ff),
      .id_kind    (id_kind)
   );

   assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
   assign is_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
                      ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));

   // Next state when a character starts a lexeme
   always_comb begin
      if (is_letter)     start_nx = ST_ID;
      else if (is_digit) start_nx = ST_INT;
      else begin
         unique case (ch)
            CH_PLUS:   start_nx = ST_PLUS;
            CH_MINUS:  start_nx = ST_MINUS;
            CH_STAR:   start_nx = ST_STAR;
            CH_SLASH:  start_nx = ST_SLASH;
            CH_EQ:     start_nx = ST_EQ;
            CH_LT:     start_nx = ST_LT;
            CH_GT:     start_nx = ST_GT;
            CH_COLON:  start_nx = ST_COLON;
            CH_LPAREN: start_nx = ST_LPAREN;
            CH_RPAREN: start_nx = ST_RPAREN;
            CH_LBRACK: start_nx = ST_LBRACK;
            CH_RBRACK: start_nx = ST_RBRACK;
            CH_SEMI:   start_nx = ST_SEMI;
            CH_DOT:    start_nx = ST_DOT;
            CH_COMMA:  start_nx = ST_COMMA;
            CH_SPACE:  start_nx = ST_SPACE;
            CH_EOL:    start_nx = ST_EOL;
            default:   start_nx = ST_START;
         endcase
      end
   end

   // Next state when a character may extend the pending lexeme; start means it ends
   always_comb begin
      unique case (state_ff)
         ST_ID:    cont_nx = (is_letter || is_digit) ? ST_ID : ST_START;
         ST_INT:   cont_nx = is_digit ? ST_INT : ((ch == CH_DOT) ? ST_POINT : ST_START);
         ST_POINT,
         ST_REAL:  cont_nx = is_digit ? ST_REAL : ST_START;
         ST_LT:    cont_nx = (ch == CH_GT) ? ST_NE : ((ch == CH_EQ) ? ST_LE : ST_START);
         ST_GT:    cont_nx = (ch == CH_EQ) ? ST_GE : ST_START;
         ST_COLON: cont_nx = (ch == CH_EQ) ? ST_ASSIGN : ST_START;
         default:  cont_nx = ST_START;
      endcase
   end

   // Next values of the lexeme registers
   always_comb begin
      flush      = (state_ff != ST_START) && (is_end || cont_nx == ST_START);
      base_count = flush ? '0 : count_ff;
      base_nokw  = flush ? 1'b0 : nokw_ff;
      state_in   = state_ff;
      text_in    = text_ff;
      count_in   = count_ff;
      nokw_in    = nokw_ff;
      if (is_end) begin
         state_in = ST_START;
         count_in = '0;
         nokw_in  = 1'b0;
      end else begin
         state_in = (state_ff != ST_START && !flush) ? cont_nx : start_nx;
         nokw_in  = base_nokw || (state_ff == ST_START || flush) && (start_nx == ST_START);
         if (base_count < LEN_W'(BUF_LEN)) text_in = {text_ff[TEXT_W-CH_W-1:0], ch};
         count_in = (base_count == '1) ? base_count : base_count + LEN_W'(1);
      end
   end

   // Kind of the pending lexeme
   always_comb begin
      unique case (state_ff)
         ST_ID:           pend_kind = id_kind;
         ST_INT, ST_REAL: pend_kind = K_NUM;
         ST_POINT:        pend_kind = K_ERR;
         default: begin
            if (state_ff >= ST_PLUS && state_ff <= ST_EOL)
               pend_kind = KIND_W'(state_ff) - OP_KIND_OFFSET;
            else
               pend_kind = K_ERR;
         end
      endcase
   end

   // Results of this transaction
   always_comb begin
      push.lex_vld                = accept && flush;
      push.eof_vld                = accept && is_end;
      push.lex_item.kind          = pend_kind;
      push.lex_item.lexeme_length = count_ff;
      push.lex_item.last          = !is_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= '0;
         nokw_ff  <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
         nokw_ff  <= nokw_in;
      end
   end

   // text buffer is payload: entries past the count are never compared
   always_ff @(posedge clock) begin
      if (accept) text_ff <= text_in;
   end

endmodule

// ===== rtl/plx_rsp_queue.sv =====
// Result queue: takes up to two results per transaction, sends one per cycle
// while out_rdy is high. Depends on plx_pkg.
module plx_rsp_queue
   import plx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         room,
   output logic         out_vld,
   input  logic         out_rdy,
   output rsp_item_type out_item
);

   localparam rsp_item_type EOF_ITEM = '{kind: K_EOF, lexeme_length: '0, last: 1'b1};

   rsp_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;
   logic [QCNT_W-1:0]  n_push;

   assign room     = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_vld  = count_ff != '0;
   assign out_item = slot_ff[rd_ptr_ff];
   assign pop      = out_vld && out_rdy;
   assign n_push   = QCNT_W'(push.lex_vld) + QCNT_W'(push.eof_vld);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + n_push - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Lexeme result first, end token behind it
   always_ff @(posedge clock) begin
      if (push.lex_vld) begin
         slot_ff[wr_ptr_ff] <= push.lex_item;
         if (push.eof_vld) slot_ff[wr_ptr_ff + QPTR_W'(1)] <= EOF_ITEM;
      end else if (push.eof_vld) begin
         slot_ff[wr_ptr_ff] <= EOF_ITEM;
      end
   end

endmodule
